// File: rtl/spdsr_pkg.sv
// spdsr_pkg: shared codes, result bundle and rate classifier for the
// S/PDIF sample-rate detector. No dependencies.
`timescale 1ns / 1ps

package spdsr_pkg;

    // request kinds
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_STOP = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;

    // detect phases
    localparam logic [2:0] PHASE_DETECT       = 3'd0;
    localparam logic [2:0] PHASE_DETECT_32K   = 3'd1;
    localparam logic [2:0] PHASE_REDETECT     = 3'd2;
    localparam logic [2:0] PHASE_REDETECT_32K = 3'd3;
    localparam logic [2:0] PHASE_FINISHED     = 3'd4;

    // rate codes, plus two internal classifier outcomes
    localparam logic [3:0] RATE_32K     = 4'd0;
    localparam logic [3:0] RATE_44K1    = 4'd1;
    localparam logic [3:0] RATE_48K     = 4'd2;
    localparam logic [3:0] RATE_64K     = 4'd3;
    localparam logic [3:0] RATE_88K2    = 4'd4;
    localparam logic [3:0] RATE_96K     = 4'd5;
    localparam logic [3:0] RATE_128K    = 4'd6;
    localparam logic [3:0] RATE_176K4   = 4'd7;
    localparam logic [3:0] RATE_192K    = 4'd8;
    localparam logic [3:0] RATE_RECHECK = 4'd9;
    localparam logic [3:0] RATE_NONE    = 4'd10;

    // configuration register indexes
    localparam logic [7:0] CFG_SETTLE_TICKS  = 8'd0;
    localparam logic [7:0] CFG_TIMEOUT_TICKS = 8'd1;

    localparam logic [7:0] SETTLE_TICKS_RST  = 8'd4;
    localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd20;
    localparam logic [7:0] COUNT_MAX         = 8'hFF;

    typedef struct packed {
        logic       rate_found;
        logic [3:0] rate_code;
        logic       detector_enable;
        logic       detector_disable;
        logic       level_write;
        logic       level_high;
        logic       receiver_restart;
        logic       receiver_stop;
        logic       underflow;
        logic [2:0] detect_phase;
    } result_t;

    // range classifier on the byte sum of the detector count
    function automatic logic [3:0] classify(input logic [8:0] s);
        logic [3:0] r;
        r = RATE_NONE;
        if (s >= 9'h062 && s <= 9'h066)      r = RATE_48K;
        else if (s >= 9'h031 && s <= 9'h033) r = RATE_96K;
        else if (s >= 9'h018 && s <= 9'h01B) r = RATE_192K;
        else if (s >= 9'h06A && s <= 9'h06E) r = RATE_44K1;
        else if (s >= 9'h035 && s <= 9'h037) r = RATE_88K2;
        else if (s >= 9'h01C && s <= 9'h01D) r = RATE_176K4;
        else if (s >= 9'h120 && s <= 9'h12C) r = RATE_RECHECK;
        else if (s >= 9'h050 && s <= 9'h052) r = RATE_64K;
        if (s >= 9'h024 && s <= 9'h027)      r = RATE_128K;
        return r;
    endfunction

endpackage

// File: rtl/spdsr_core.sv
// spdsr_core: detect phase machine, settle and no-data timeout counters.
// Depends on spdsr_pkg; result is combinational from the accepted request.
`timescale 1ns / 1ps

module spdsr_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [1:0]          kind,
    input  logic [15:0]         rate_count,
    input  logic [7:0]          settle_ticks,
    input  logic [7:0]          timeout_ticks,
    output spdsr_pkg::result_t  result
);
    import spdsr_pkg::*;

    logic [2:0] phase_reg, phase_next;
    logic [7:0] settle_reg, settle_next;
    logic       waiting_reg, waiting_next;
    logic [7:0] wait_cnt_reg, wait_cnt_next;

    // next state and result for one request
    always_comb begin
        logic [8:0] sum;
        logic [3:0] r;
        result_t    res;
        phase_next    = phase_reg;
        settle_next   = settle_reg;
        waiting_next  = waiting_reg;
        wait_cnt_next = wait_cnt_reg;
        res           = '0;
        sum           = {1'b0, rate_count[7:0]} + {1'b0, rate_count[15:8]};
        r             = RATE_NONE;
        unique case (kind)
            KIND_TICK: begin
                if (phase_reg == PHASE_DETECT || phase_reg == PHASE_DETECT_32K) begin
                    if (settle_next != COUNT_MAX) settle_next = settle_next + 8'd1;
                    if (settle_next >= settle_ticks) begin
                        if (phase_reg == PHASE_DETECT_32K) begin
                            r = (sum >= 9'h030 && sum <= 9'h032) ? RATE_32K : RATE_NONE;
                        end else begin
                            r = classify(sum);
                        end
                        res.detector_disable = 1'b1;
                        if (r <= RATE_192K) begin
                            res.rate_found       = 1'b1;
                            res.rate_code        = r;
                            res.receiver_restart = 1'b1;
                            phase_next           = PHASE_FINISHED;
                            waiting_next         = 1'b1;
                            wait_cnt_next        = '0;
                        end else if (r == RATE_RECHECK) begin
                            res.level_write = 1'b1;
                            phase_next      = PHASE_REDETECT_32K;
                        end else begin
                            res.level_write = 1'b1;
                            res.level_high  = 1'b1;
                            phase_next      = PHASE_REDETECT;
                        end
                    end
                end else if (phase_reg == PHASE_REDETECT ||
                             phase_reg == PHASE_REDETECT_32K) begin
                    res.detector_enable = 1'b1;
                    settle_next         = '0;
                    phase_next          = (phase_reg == PHASE_REDETECT) ?
                                          PHASE_DETECT : PHASE_DETECT_32K;
                end
                // no-data timeout, after the phase work
                if (waiting_next) begin
                    if (wait_cnt_next != COUNT_MAX) wait_cnt_next = wait_cnt_next + 8'd1;
                    if (wait_cnt_next > timeout_ticks) begin
                        res.underflow = 1'b1;
                        wait_cnt_next = '0;
                    end
                end
            end
            KIND_STOP: begin
                res.receiver_stop = 1'b1;
                settle_next       = '0;
                phase_next        = PHASE_REDETECT;
                waiting_next      = 1'b0;
                wait_cnt_next     = '0;
            end
            KIND_DATA: begin
                waiting_next = 1'b0;
            end
            default: begin
            end
        endcase
        res.detect_phase = phase_next;
        result           = res;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PHASE_DETECT;
            settle_reg   <= '0;
            waiting_reg  <= 1'b0;
            wait_cnt_reg <= '0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            settle_reg   <= settle_next;
            waiting_reg  <= waiting_next;
            wait_cnt_reg <= wait_cnt_next;
        end
    end

endmodule

// File: rtl/spdif_sample_rate_detector.sv
// spdif_sample_rate_detector: top level with config registers and a
// two-entry result queue. Depends on spdsr_pkg and spdsr_core.
//
//  channel | ports                   | direction | request moves
//  --------+-------------------------+-----------+--------------------------
//  s_      | s_valid s_ready s_kind  | in        | tick, stop or data event
//          | s_rate_count            |           |
//  m_      | m_valid m_ready m_*     | out       | one result per request
//  cfg_    | cfg_valid cfg_ready     | in        | register index and data
//          | cfg_index cfg_data      |           |
//
// One request per cycle while s_ready is high; each result is registered at acceptance.
// The state machine and counters update at the accepting edge, result goes
// into a head register backed by one skid entry, so s_ready drops only
// when both entries are held. Configuration is always ready.
// Reset (aresetn low, synchronous) restores phase detect, clears counters
// and empties the result queue; config returns to settle 4, timeout 20.
`timescale 1ns / 1ps

module spdif_sample_rate_detector (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [15:0] s_rate_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_rate_found,
    output logic [3:0]  m_rate_code,
    output logic        m_detector_enable,
    output logic        m_detector_disable,
    output logic        m_level_write,
    output logic        m_level_high,
    output logic        m_receiver_restart,
    output logic        m_receiver_stop,
    output logic        m_underflow,
    output logic [2:0]  m_detect_phase,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import spdsr_pkg::*;

    logic [7:0] settle_ticks_reg;
    logic [7:0] timeout_ticks_reg;
    result_t    core_res;
    result_t    head_reg, head_next;
    result_t    skid_reg, skid_next;
    logic       head_vld_reg, head_vld_next;
    logic       skid_vld_reg, skid_vld_next;
    logic       accept;
    logic       pop;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_vld_reg;
    assign accept    = s_valid && s_ready;
    assign pop       = head_vld_reg && m_ready;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_ticks_reg  <= SETTLE_TICKS_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_SETTLE_TICKS)  settle_ticks_reg  <= cfg_data;
            if (cfg_index == CFG_TIMEOUT_TICKS) timeout_ticks_reg <= cfg_data;
        end
    end

    spdsr_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .kind          (s_kind),
        .rate_count    (s_rate_count),
        .settle_ticks  (settle_ticks_reg),
        .timeout_ticks (timeout_ticks_reg),
        .result        (core_res)
    );

    // head plus skid result queue
    always_comb begin
        head_next     = head_reg;
        skid_next     = skid_reg;
        head_vld_next = head_vld_reg;
        skid_vld_next = skid_vld_reg;
        if (pop || !head_vld_reg) begin
            if (skid_vld_reg) begin
                head_next     = skid_reg;
                head_vld_next = 1'b1;
                skid_next     = core_res;
                skid_vld_next = accept;
            end else begin
                head_next     = core_res;
                head_vld_next = accept;
                skid_vld_next = 1'b0;
            end
        end else if (accept) begin
            skid_next     = core_res;
            skid_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            head_vld_reg <= head_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    // result ports
    assign m_valid            = head_vld_reg;
    assign m_rate_found       = head_reg.rate_found;
    assign m_rate_code        = head_reg.rate_code;
    assign m_detector_enable  = head_reg.detector_enable;
    assign m_detector_disable = head_reg.detector_disable;
    assign m_level_write      = head_reg.level_write;
    assign m_level_high       = head_reg.level_high;
    assign m_receiver_restart = head_reg.receiver_restart;
    assign m_receiver_stop    = head_reg.receiver_stop;
    assign m_underflow        = head_reg.underflow;
    assign m_detect_phase     = head_reg.detect_phase;

endmodule

// File: rtl/spdsr_checker.sv
// spdsr_props: port-level assertions for spdif_sample_rate_detector,
// bound to the top level below. Depends on spdsr_pkg.
`timescale 1ns / 1ps

module spdsr_props (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_rate_found,
    input logic [3:0]  m_rate_code,
    input logic        m_detector_disable,
    input logic        m_level_write,
    input logic        m_level_high,
    input logic        m_receiver_restart,
    input logic [2:0]  m_detect_phase
);
    import spdsr_pkg::*;

    // queue is empty right after reset
    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_detect_phase)
                                   && $stable(m_rate_found) && $stable(m_rate_code)))
        else $error("stalled result changed");

    // a found rate restarts the receiver and finishes detection
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rate_found) |-> (m_receiver_restart && m_detector_disable
                                       && m_detect_phase == PHASE_FINISHED
                                       && m_rate_code <= RATE_192K))
        else $error("found rate without restart or finished phase");

    // level is only driven with a level write, and a level write never finds a rate
    a_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_level_high || m_level_write)) |->
            (m_level_write && m_detector_disable && !m_rate_found))
        else $error("inconsistent level write");

    // two results pending without a take blocks new requests
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && m_valid && !m_ready) |=> !s_ready)
        else $error("request accepted beyond queue depth");

endmodule

bind spdif_sample_rate_detector spdsr_props u_spdsr_props (.*);

// File: tb/spdsr_checker.sv
// spdsr_checker: watches the request, result and config channels of the
// sample-rate detector, predicts each result and compares it field by field.
// Depends on spdsr_pkg for codes and the result layout.
`timescale 1ns / 1ps

module spdsr_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [15:0] s_rate_count,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_rate_found,
    input  logic [3:0]  m_rate_code,
    input  logic        m_detector_enable,
    input  logic        m_detector_disable,
    input  logic        m_level_write,
    input  logic        m_level_high,
    input  logic        m_receiver_restart,
    input  logic        m_receiver_stop,
    input  logic        m_underflow,
    input  logic [2:0]  m_detect_phase,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        run_done,
    output int          fail_count
);
    import spdsr_pkg::*;

    localparam int MAX_PRINTS = 40;

    // shadow of the detector state and its registers
    logic [7:0] settle_lim;
    logic [7:0] timeout_lim;
    logic [2:0] phase_q;
    logic [7:0] settle_cnt;
    logic       waiting;
    logic [7:0] wait_cnt;

    result_t     pending_results[$];
    int unsigned n_checked;
    bit          leftover_checked;

    initial begin
        fail_count       = 0;
        n_checked        = 0;
        leftover_checked = 1'b0;
    end

    // print one line per mismatch, keep counting after the print cap
    task automatic report_mismatch(input string what, input logic [15:0] got_v,
                                   input logic [15:0] want_v);
        if (fail_count < MAX_PRINTS)
            $display("ERROR: result %0d: %s got %0h expected %0h", n_checked, what,
                     got_v, want_v);
        fail_count++;
    endtask

    // fixed rate windows on the byte sum
    function automatic logic [3:0] rate_from_sum(input logic [8:0] s);
        if (s >= 9'h120 && s <= 9'h12C) return RATE_RECHECK;
        if (s > 9'h06E) return RATE_NONE;
        if (s >= 9'h06A) return RATE_44K1;
        if (s >= 9'h062 && s <= 9'h066) return RATE_48K;
        if (s >= 9'h050 && s <= 9'h052) return RATE_64K;
        if (s >= 9'h035 && s <= 9'h037) return RATE_88K2;
        if (s >= 9'h031 && s <= 9'h033) return RATE_96K;
        if (s >= 9'h024 && s <= 9'h027) return RATE_128K;
        if (s >= 9'h01C && s <= 9'h01D) return RATE_176K4;
        if (s >= 9'h018 && s <= 9'h01B) return RATE_192K;
        return RATE_NONE;
    endfunction

    // advance the shadow state by one request and return its result
    function automatic result_t predict_detect(input logic [1:0] kind,
                                               input logic [15:0] cnt);
        result_t    r;
        logic [8:0] sum;
        logic [3:0] cls;
        r = '0;
        case (kind)
            KIND_TICK: begin
                if (phase_q == PHASE_DETECT || phase_q == PHASE_DETECT_32K) begin
                    if (settle_cnt != COUNT_MAX) settle_cnt = settle_cnt + 8'd1;
                    if (settle_cnt >= settle_lim) begin
                        sum = {1'b0, cnt[7:0]} + {1'b0, cnt[15:8]};
                        if (phase_q == PHASE_DETECT_32K)
                            cls = (sum >= 9'h030 && sum <= 9'h032) ? RATE_32K : RATE_NONE;
                        else
                            cls = rate_from_sum(sum);
                        r.detector_disable = 1'b1;
                        if (cls <= RATE_192K) begin
                            r.rate_found       = 1'b1;
                            r.rate_code        = cls;
                            r.receiver_restart = 1'b1;
                            phase_q            = PHASE_FINISHED;
                            waiting            = 1'b1;
                            wait_cnt           = 8'd0;
                        end else if (cls == RATE_RECHECK) begin
                            r.level_write = 1'b1;
                            phase_q       = PHASE_REDETECT_32K;
                        end else begin
                            r.level_write = 1'b1;
                            r.level_high  = 1'b1;
                            phase_q       = PHASE_REDETECT;
                        end
                    end
                end else if (phase_q == PHASE_REDETECT || phase_q == PHASE_REDETECT_32K) begin
                    r.detector_enable = 1'b1;
                    settle_cnt        = 8'd0;
                    phase_q = (phase_q == PHASE_REDETECT) ? PHASE_DETECT : PHASE_DETECT_32K;
                end
                // no-data timeout after a rate was found
                if (waiting) begin
                    if (wait_cnt != COUNT_MAX) wait_cnt = wait_cnt + 8'd1;
                    if (wait_cnt > timeout_lim) begin
                        r.underflow = 1'b1;
                        wait_cnt    = 8'd0;
                    end
                end
            end
            KIND_STOP: begin
                r.receiver_stop = 1'b1;
                settle_cnt      = 8'd0;
                phase_q         = PHASE_REDETECT;
                waiting         = 1'b0;
                wait_cnt        = 8'd0;
            end
            KIND_DATA: begin
                waiting = 1'b0;
            end
            default: begin
            end
        endcase
        r.detect_phase = phase_q;
        return r;
    endfunction

    // compare one delivered result with the oldest prediction
    task automatic check_result();
        result_t got, want;
        got = {m_rate_found, m_rate_code, m_detector_enable, m_detector_disable,
               m_level_write, m_level_high, m_receiver_restart, m_receiver_stop,
               m_underflow, m_detect_phase};
        if (pending_results.size() == 0) begin
            report_mismatch("results beyond requests", 16'd1, 16'd0);
        end else begin
            want = pending_results.pop_front();
            if (got.rate_found !== want.rate_found)
                report_mismatch("rate_found", 16'(got.rate_found), 16'(want.rate_found));
            if (got.rate_code !== want.rate_code)
                report_mismatch("rate_code", 16'(got.rate_code), 16'(want.rate_code));
            if (got.detector_enable !== want.detector_enable)
                report_mismatch("detector_enable", 16'(got.detector_enable),
                                16'(want.detector_enable));
            if (got.detector_disable !== want.detector_disable)
                report_mismatch("detector_disable", 16'(got.detector_disable),
                                16'(want.detector_disable));
            if (got.level_write !== want.level_write)
                report_mismatch("level_write", 16'(got.level_write),
                                16'(want.level_write));
            if (got.level_high !== want.level_high)
                report_mismatch("level_high", 16'(got.level_high), 16'(want.level_high));
            if (got.receiver_restart !== want.receiver_restart)
                report_mismatch("receiver_restart", 16'(got.receiver_restart),
                                16'(want.receiver_restart));
            if (got.receiver_stop !== want.receiver_stop)
                report_mismatch("receiver_stop", 16'(got.receiver_stop),
                                16'(want.receiver_stop));
            if (got.underflow !== want.underflow)
                report_mismatch("underflow", 16'(got.underflow), 16'(want.underflow));
            if (got.detect_phase !== want.detect_phase)
                report_mismatch("detect_phase", 16'(got.detect_phase),
                                16'(want.detect_phase));
        end
        n_checked++;
    endtask

    // channel monitor: results are checked before new requests are queued
    always @(posedge aclk) begin
        if (!aresetn) begin
            settle_lim  = SETTLE_TICKS_RST;
            timeout_lim = TIMEOUT_TICKS_RST;
            phase_q     = PHASE_DETECT;
            settle_cnt  = 8'd0;
            waiting     = 1'b0;
            wait_cnt    = 8'd0;
            pending_results.delete();
        end else begin
            if (m_valid && m_ready) check_result();
            if (s_valid && s_ready)
                pending_results.push_back(predict_detect(s_kind, s_rate_count));
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SETTLE_TICKS) settle_lim = cfg_data;
                else if (cfg_index == CFG_TIMEOUT_TICKS) timeout_lim = cfg_data;
            end
            // nothing may be left waiting once the run is over
            if (run_done && !leftover_checked) begin
                leftover_checked = 1'b1;
                if (pending_results.size() != 0)
                    report_mismatch("results delivered", 16'd0,
                                    16'(pending_results.size()));
            end
        end
    end

endmodule

// File: tb/tb.sv
// tb: stimulus and verdict for spdif_sample_rate_detector. Drives requests,
// config writes and result back-pressure; checking is done in spdsr_checker.
// Depends on spdsr_pkg, the detector RTL and spdsr_checker.
`timescale 1ns / 1ps

module tb;
    import spdsr_pkg::*;

    localparam int         RESET_CYCLES  = 9;
    localparam int         HOLD_CYCLES   = 200;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         FLUSH_CYCLES  = 8;
    localparam int         NUM_PHASES    = 8;
    localparam int         QUIET_ITEMS   = 280;
    localparam int         MIXED_ITEMS   = 27;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam logic [7:0] CFG_UNUSED    = 8'd2;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind       = KIND_TICK;
    logic [15:0] s_rate_count = 16'd0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic        m_rate_found;
    logic [3:0]  m_rate_code;
    logic        m_detector_enable;
    logic        m_detector_disable;
    logic        m_level_write;
    logic        m_level_high;
    logic        m_receiver_restart;
    logic        m_receiver_stop;
    logic        m_underflow;
    logic [2:0]  m_detect_phase;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index    = CFG_SETTLE_TICKS;
    logic [7:0]  cfg_data     = 8'd0;
    logic        run_done     = 1'b0;
    int          fail_count;

    bit idle_on     = 1'b1;
    bit drain_hold  = 1'b0;
    int n_sent      = 0;
    int n_recv      = 0;
    int cycle_count = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    spdif_sample_rate_detector i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_rate_count       (s_rate_count),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_rate_found       (m_rate_found),
        .m_rate_code        (m_rate_code),
        .m_detector_enable  (m_detector_enable),
        .m_detector_disable (m_detector_disable),
        .m_level_write      (m_level_write),
        .m_level_high       (m_level_high),
        .m_receiver_restart (m_receiver_restart),
        .m_receiver_stop    (m_receiver_stop),
        .m_underflow        (m_underflow),
        .m_detect_phase     (m_detect_phase),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    spdsr_checker i_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_rate_count       (s_rate_count),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_rate_found       (m_rate_found),
        .m_rate_code        (m_rate_code),
        .m_detector_enable  (m_detector_enable),
        .m_detector_disable (m_detector_disable),
        .m_level_write      (m_level_write),
        .m_level_high       (m_level_high),
        .m_receiver_restart (m_receiver_restart),
        .m_receiver_stop    (m_receiver_stop),
        .m_underflow        (m_underflow),
        .m_detect_phase     (m_detect_phase),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .run_done           (run_done),
        .fail_count         (fail_count)
    );

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // detector count whose byte sum mostly lands in or next to a rate window
    function automatic logic [15:0] make_rate_count();
        int         sel;
        int         s;
        int         lo;
        logic [7:0] lo_b;
        logic [7:0] hi_b;
        sel = $urandom_range(0, 99);
        if (sel >= 75) return 16'($urandom());
        if (sel >= 65) begin
            s = $urandom_range(32'h11F, 32'h12D);
        end else if (sel >= 55) begin
            s = $urandom_range(32'h2F, 32'h33);
        end else begin
            case ($urandom_range(0, 7))
                0: s = $urandom_range(32'h17, 32'h1C);
                1: s = $urandom_range(32'h1B, 32'h1E);
                2: s = $urandom_range(32'h23, 32'h28);
                3: s = $urandom_range(32'h30, 32'h34);
                4: s = $urandom_range(32'h34, 32'h38);
                5: s = $urandom_range(32'h4F, 32'h53);
                6: s = $urandom_range(32'h61, 32'h67);
                default: s = $urandom_range(32'h69, 32'h6F);
            endcase
        end
        // random split of the sum over the two bytes
        lo   = $urandom_range((s > 255) ? s - 255 : 0, (s < 255) ? s : 255);
        lo_b = lo[7:0];
        hi_b = 8'(s - lo);
        return {hi_b, lo_b};
    endfunction

    // offer one request after a random gap; valid stays up after acceptance
    task automatic send_req(input logic [1:0] kind, input logic [15:0] cnt);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        repeat (gap) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_rate_count <= cnt;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    // drop valid and wait until every request has its result back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (n_recv != n_sent);
    endtask

    // write both registers back to back, optionally poking an unused index first
    task automatic program_regs(input logic [7:0] settle, input logic [7:0] timeout,
                                input bit poke_unused);
        if (poke_unused) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_UNUSED;
            cfg_data  <= 8'($urandom());
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SETTLE_TICKS;
        cfg_data  <= settle;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_TIMEOUT_TICKS;
        cfg_data  <= timeout;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : result_drain
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (drain_hold) begin
                stall      = HOLD_CYCLES;
                drain_hold = 1'b0;
            end else begin
                stall = idle_on ? $urandom_range(0, 8) : 0;
            end
            repeat (stall) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            n_recv++;
        end
    end

    // stimulus
    initial begin : stimulus
        logic [7:0] settle_v;
        logic [7:0] timeout_v;
        bit         quiet;
        int         n_items;
        int         sel;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, settle then 48k, data, unused kind, stop
        repeat (3) send_req(KIND_TICK, 16'h0000);
        send_req(KIND_TICK, 16'h3232);
        send_req(KIND_TICK, 16'hFFFF);
        send_req(KIND_DATA, 16'h5A5A);
        send_req(KIND_UNUSED, 16'hA5A5);
        send_req(KIND_STOP, 16'h0000);
        wait_drained();

        // directed: shortest settle and timeout, 32k recheck paths, underflow
        program_regs(8'd1, 8'd1, 1'b1);
        send_req(KIND_TICK, 16'h0000);
        send_req(KIND_TICK, 16'hFF21);
        send_req(KIND_TICK, 16'h0000);
        send_req(KIND_TICK, 16'h1234);
        send_req(KIND_TICK, 16'h0000);
        send_req(KIND_TICK, 16'h2DFF);
        send_req(KIND_TICK, 16'h0000);
        send_req(KIND_TICK, 16'h0032);
        repeat (3) send_req(KIND_TICK, 16'h0000);
        send_req(KIND_STOP, 16'hFFFF);
        send_req(KIND_TICK, 16'h0000);
        send_req(KIND_TICK, 16'hFFFF);
        send_req(KIND_TICK, 16'h0000);
        send_req(KIND_TICK, 16'h1311);
        send_req(KIND_STOP, 16'h0000);
        send_req(KIND_TICK, 16'h0000);
        send_req(KIND_TICK, 16'h0E0E);
        wait_drained();

        // random phases, each with its own register setting
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    settle_v  = 8'd1;
                    timeout_v = 8'd255;
                end
                1: begin
                    settle_v  = 8'd255;
                    timeout_v = 8'($urandom_range(1, 40));
                end
                3: begin
                    settle_v  = 8'($urandom_range(1, 6));
                    timeout_v = 8'd1;
                end
                default: begin
                    settle_v  = 8'($urandom_range(1, 6));
                    timeout_v = 8'($urandom_range(1, 30));
                end
            endcase
            program_regs(settle_v, timeout_v, 1'b0);
            idle_on = (p % 3 != 2);
            quiet   = (p < 2);
            n_items = quiet ? QUIET_ITEMS : MIXED_ITEMS;
            // receiver holds off while the sender keeps offering
            if (p == 4) drain_hold = 1'b1;

            if (quiet) begin
                // long tick runs: full settle count and saturated wait count
                send_req(KIND_STOP, 16'($urandom()));
                for (int i = 0; i < n_items; i++)
                    send_req(KIND_TICK, make_rate_count());
            end else begin
                for (int i = 0; i < n_items; i++) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 72) send_req(KIND_TICK, make_rate_count());
                    else if (sel < 82) send_req(KIND_DATA, 16'($urandom()));
                    else if (sel < 92) send_req(KIND_STOP, 16'($urandom()));
                    else send_req(KIND_UNUSED, 16'($urandom()));
                end
            end
            wait_drained();
        end

        repeat (FLUSH_CYCLES) @(posedge aclk);
        run_done <= 1'b1;
        repeat (2) @(posedge aclk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
rtl/spdsr_pkg.sv
rtl/spdsr_core.sv
rtl/spdif_sample_rate_detector.sv
rtl/spdsr_checker.sv
tb/spdsr_checker.sv
tb/tb.sv
